// ----- sv/led_strip_pattern_sequencer_unit_defines.svh -----
// Assertion macros shared by the LED strip pattern sequencer RTL.
// Needs signals named clock and reset in the including module.
`ifndef LED_STRIP_PATTERN_SEQUENCER_UNIT_DEFINES_SVH
`define LED_STRIP_PATTERN_SEQUENCER_UNIT_DEFINES_SVH

// Check that cons holds in the same cycle as ante.
`define LSPS_ASSERT_NOW(name, ante, cons, msg) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Check that cons holds in the cycle after ante.
`define LSPS_ASSERT_NEXT(name, ante, cons, msg) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- sv/lsps_pkg.sv -----
// Types and constants for the LED strip pattern sequencer.
// No dependencies; imported by lsps_div, lsps_sweep and the top level.
`default_nettype none

package lsps_pkg;

   // field widths
   localparam int COLOR_W     = 32;
   localparam int PIXEL_IDX_W = 6;
   localparam int PHASE_W     = 3;
   localparam int STEPS_W     = 16;
   localparam int MS_W        = 16;
   localparam int PERIOD_W    = 25;
   localparam int PATTERN_W   = 2;

   // stream and register port widths
   localparam int REQ_DATA_W  = 8;
   localparam int REQ_USER_W  = 2;
   localparam int RSP_DATA_W  = 40;
   localparam int CSR_ADDR_W  = 2;
   localparam int CSR_DATA_W  = 32;

   // period scaler operand width
   localparam int DIVIDEND_W  = MS_W + 8;

   // timing constants (17.8 fixed point milliseconds)
   localparam int TICK_FX      = 4 * 256;
   localparam int PERIOD_MIN   = 4 * 256;
   localparam int STROBE_STEPS = 4;
   localparam int PHASE_MOD    = 8;

   // request kinds
   typedef logic [REQ_USER_W-1:0] req_kind_type;
   localparam req_kind_type REQ_TICK  = 2'd0;
   localparam req_kind_type REQ_START = 2'd1;
   localparam req_kind_type REQ_STOP  = 2'd2;

   // pattern codes
   typedef logic [PATTERN_W-1:0] pattern_type;
   localparam pattern_type PAT_STROBE = 2'd0;
   localparam pattern_type PAT_RIGHT  = 2'd1;
   localparam pattern_type PAT_LEFT   = 2'd2;
   localparam pattern_type PAT_NONE   = 2'd3;

   // register indexes
   typedef logic [CSR_ADDR_W-1:0] csr_addr_type;
   localparam csr_addr_type CSR_PATTERN = 2'd0;
   localparam csr_addr_type CSR_STEP_MS = 2'd1;
   localparam csr_addr_type CSR_LIMIT   = 2'd2;
   localparam csr_addr_type CSR_COLOR   = 2'd3;

   // sweep operations: how each pixel's new value is formed
   typedef logic [2:0] sweep_op_type;
   localparam sweep_op_type OP_COPY    = 3'd0;
   localparam sweep_op_type OP_RIGHT   = 3'd1;
   localparam sweep_op_type OP_LEFT    = 3'd2;
   localparam sweep_op_type OP_FILL    = 3'd3;
   localparam sweep_op_type OP_ROTINIT = 3'd4;

   // command from the controller to the sweep engine
   typedef struct packed {
      sweep_op_type       op;
      logic [COLOR_W-1:0] color;
      logic               running;
   } sweep_cmd_type;

endpackage

`default_nettype wire

// ----- sv/lsps_ram.sv -----
// Generic single-write, single-read synchronous RAM with registered read.
// No dependencies.
`default_nettype none

module lsps_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // read port; data holds while rd_en is low
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ----- sv/lsps_div.sv -----
// Step period scaler: divides the scaled step time by the step count of the
// pattern with a shift or a constant reciprocal multiply.
// Depends on lsps_pkg for the operand width and the pattern codes.
`default_nettype none

module lsps_div #(
   parameter int PIXEL_COUNT = 16
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             start,
   input  wire logic [lsps_pkg::DIVIDEND_W-1:0]  dividend,
   input  wire lsps_pkg::pattern_type            pattern,
   output logic                                  busy,
   output logic                                  done,
   output logic      [lsps_pkg::DIVIDEND_W-1:0]  quotient
);
   import lsps_pkg::*;

   // floor(x / PIXEL_COUNT) equals (x * RECIP_MUL) >> RECIP_SHIFT for every
   // x below 2**DIVIDEND_W
   localparam int RECIP_SHIFT = DIVIDEND_W + $clog2(PIXEL_COUNT);
   localparam int RECIP_W     = DIVIDEND_W + 1;
   localparam int PROD_W      = DIVIDEND_W + RECIP_W;
   localparam longint unsigned RECIP_MUL =
      ((64'd1 << RECIP_SHIFT) / PIXEL_COUNT) + 64'd1;
   localparam int STROBE_SHIFT = $clog2(STROBE_STEPS);

   logic                   busy_ff;
   logic                   done_ff;
   logic [DIVIDEND_W-1:0]  opnd_ff;
   pattern_type            pat_ff;
   logic [DIVIDEND_W-1:0]  quo_ff, quo_in;
   logic [PROD_W-1:0]      prod;

   // 24 x 25 bit product with the reciprocal
   assign prod = {{RECIP_W{1'b0}}, opnd_ff} * {{DIVIDEND_W{1'b0}}, RECIP_W'(RECIP_MUL)};

   // pick the quotient for the latched pattern
   always_comb begin
      unique case (pat_ff)
         PAT_STROBE: quo_in = opnd_ff >> STROBE_SHIFT;
         PAT_NONE:   quo_in = opnd_ff;
         default:    quo_in = DIVIDEND_W'(prod >> RECIP_SHIFT);
      endcase
   end

   // control: latch operands, then register the quotient
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= start;
         done_ff <= busy_ff;
      end
   end

   // datapath
   always_ff @(posedge clock) begin
      if (start) begin
         opnd_ff <= dividend;
         pat_ff  <= pattern;
      end
      if (busy_ff) begin
         quo_ff <= quo_in;
      end
   end

   assign busy     = busy_ff;
   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

`default_nettype wire

// ----- sv/lsps_sweep.sv -----
// Pixel sweep engine: two ping-pong pixel RAMs, read-modify-write of every
// pixel in index order, and the result output register.
// Depends on lsps_pkg, lsps_ram and the assertion macro header.
`default_nettype none
`include "led_strip_pattern_sequencer_unit_defines.svh"

module lsps_sweep #(
   parameter int PIXEL_COUNT = 16
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             start,
   input  wire lsps_pkg::sweep_cmd_type          cmd,
   output logic                                  busy,
   output logic                                  done,
   output logic                                  rsp_tvalid,
   input  wire logic                             rsp_tready,
   // rsp_tdata, low bit up: pixel_index[5:0], pixel_color[37:6], zero[39:38]
   output logic      [lsps_pkg::RSP_DATA_W-1:0]  rsp_tdata,
   output logic                                  rsp_tlast,
   // rsp_tuser: is_running
   output logic                                  rsp_tuser
);
   import lsps_pkg::*;

   localparam int AW = $clog2(PIXEL_COUNT);
   localparam logic [AW-1:0] LAST_IDX = AW'(PIXEL_COUNT - 1);

   logic                busy_ff, busy_in;
   sweep_cmd_type       cmd_ff;
   logic                iss_active_ff, iss_active_in;
   logic [AW-1:0]       iss_idx_ff, iss_idx_in;
   logic                b_valid_ff, b_valid_in;
   logic [AW-1:0]       b_idx_ff;
   logic                bank_ff;
   logic                store_valid_ff;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [AW-1:0]       rsp_idx_ff;
   logic [COLOR_W-1:0]  rsp_color_ff;
   logic                rsp_last_ff;
   logic                rsp_run_ff;

   logic                out_free;
   logic                fire_b;
   logic                issue;
   logic [AW-1:0]       src_addr;
   logic [COLOR_W-1:0]  rd_data0, rd_data1;
   logic [COLOR_W-1:0]  old_color;
   logic [COLOR_W-1:0]  new_color;

   // handshake between the read stage and the output register
   assign out_free = !rsp_valid_ff || rsp_tready;
   assign fire_b   = b_valid_ff && out_free;
   assign issue    = iss_active_ff && (!b_valid_ff || out_free);
   assign done     = fire_b && (b_idx_ff == LAST_IDX);

   // source pixel for the index being issued
   always_comb begin
      unique case (cmd_ff.op)
         OP_RIGHT: src_addr = (iss_idx_ff == '0) ? LAST_IDX : iss_idx_ff - AW'(1);
         OP_LEFT:  src_addr = (iss_idx_ff == LAST_IDX) ? '0 : iss_idx_ff + AW'(1);
         default:  src_addr = iss_idx_ff;
      endcase
   end

   // read from the current bank, write the other one
   lsps_ram #(.WIDTH(COLOR_W), .DEPTH(PIXEL_COUNT)) u_bank0 (
      .clock   (clock),
      .wr_en   (fire_b && bank_ff),
      .wr_addr (b_idx_ff),
      .wr_data (new_color),
      .rd_en   (issue && !bank_ff),
      .rd_addr (src_addr),
      .rd_data (rd_data0)
   );

   lsps_ram #(.WIDTH(COLOR_W), .DEPTH(PIXEL_COUNT)) u_bank1 (
      .clock   (clock),
      .wr_en   (fire_b && !bank_ff),
      .wr_addr (b_idx_ff),
      .wr_data (new_color),
      .rd_en   (issue && bank_ff),
      .rd_addr (src_addr),
      .rd_data (rd_data1)
   );

   // the store reads as zero until the first full sweep has written it
   assign old_color = store_valid_ff ? (bank_ff ? rd_data1 : rd_data0) : '0;

   // form the new pixel value
   always_comb begin
      unique case (cmd_ff.op)
         OP_FILL:    new_color = cmd_ff.color;
         OP_ROTINIT: new_color = (b_idx_ff[1:0] == 2'b00) ? cmd_ff.color : '0;
         default:    new_color = old_color;
      endcase
   end

   // sweep control
   always_comb begin
      busy_in       = busy_ff;
      iss_active_in = iss_active_ff;
      iss_idx_in    = iss_idx_ff;
      b_valid_in    = b_valid_ff;
      rsp_valid_in  = rsp_valid_ff;
      if (start) begin
         busy_in       = 1'b1;
         iss_active_in = 1'b1;
         iss_idx_in    = '0;
      end
      if (issue) begin
         b_valid_in    = 1'b1;
         iss_idx_in    = iss_idx_ff + AW'(1);
         iss_active_in = (iss_idx_ff != LAST_IDX);
      end else if (fire_b) begin
         b_valid_in = 1'b0;
      end
      if (done) begin
         busy_in = 1'b0;
      end
      if (fire_b) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff        <= 1'b0;
         iss_active_ff  <= 1'b0;
         iss_idx_ff     <= '0;
         b_valid_ff     <= 1'b0;
         bank_ff        <= 1'b0;
         store_valid_ff <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         busy_ff       <= busy_in;
         iss_active_ff <= iss_active_in;
         iss_idx_ff    <= iss_idx_in;
         b_valid_ff    <= b_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
         // flip banks once the last pixel is written
         if (done) begin
            bank_ff        <= !bank_ff;
            store_valid_ff <= 1'b1;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (start) begin
         cmd_ff <= cmd;
      end
      if (issue) begin
         b_idx_ff <= iss_idx_ff;
      end
      if (fire_b) begin
         rsp_idx_ff   <= b_idx_ff;
         rsp_color_ff <= new_color;
         rsp_last_ff  <= (b_idx_ff == LAST_IDX);
         rsp_run_ff   <= cmd_ff.running;
      end
   end

   assign busy       = busy_ff;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {2'b00, rsp_color_ff, PIXEL_IDX_W'(rsp_idx_ff)};
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tuser  = rsp_run_ff;

   `LSPS_ASSERT_NOW(a_start_when_free, start, !busy_ff, "sweep started while busy")
   `LSPS_ASSERT_NOW(a_stage_in_sweep, b_valid_ff || iss_active_ff, busy_ff,
                    "pixel in flight outside a sweep")
   `LSPS_ASSERT_NEXT(a_bank_flip, done, bank_ff != $past(bank_ff),
                     "banks did not swap after the last pixel")
   `LSPS_ASSERT_NOW(a_last_index, rsp_valid_ff && rsp_last_ff, rsp_idx_ff == LAST_IDX,
                    "last marker on a pixel other than the final one")

endmodule

`default_nettype wire

// ----- sv/led_strip_pattern_sequencer_unit.sv -----
// Top level of the LED strip pattern sequencer: request decode, timing
// state, configuration registers. Depends on lsps_pkg, lsps_div, lsps_sweep
// and the assertion macro header.
//
//   channel | dir | handshake             | content
//   req     | in  | req_tvalid/req_tready | tuser request kind, tdata clear_on_stop
//   rsp     | out | rsp_tvalid/rsp_tready | tdata index and color, tlast, tuser running
//   csr     | in  | csr_we                | register index and write data
//
// A request that emits pixels streams PIXEL_COUNT results through the pixel RAM,
// one per cycle unless rsp_tready holds them back; the next request is taken once
// the last result enters the output register. A start request runs the period
// scaler (shift or reciprocal multiply); the next request is taken once it is done.
// Other requests leave the unit idle. Results stall in the output register; the
// sweep then holds in place. Reset is synchronous and needs no clearing pass.
`default_nettype none
`include "led_strip_pattern_sequencer_unit_defines.svh"

module led_strip_pattern_sequencer_unit #(
   parameter int PIXEL_COUNT = 16
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             req_tvalid,
   output logic                                  req_tready,
   // req_tdata, low bit up: clear_on_stop[0], zero[7:1]
   input  wire logic [lsps_pkg::REQ_DATA_W-1:0]  req_tdata,
   // req_tuser: req_type[1:0]
   input  wire logic [lsps_pkg::REQ_USER_W-1:0]  req_tuser,
   output logic                                  rsp_tvalid,
   input  wire logic                             rsp_tready,
   // rsp_tdata, low bit up: pixel_index[5:0], pixel_color[37:6], zero[39:38]
   output logic      [lsps_pkg::RSP_DATA_W-1:0]  rsp_tdata,
   output logic                                  rsp_tlast,
   // rsp_tuser: is_running
   output logic                                  rsp_tuser,
   input  wire logic                             csr_we,
   input  wire logic [lsps_pkg::CSR_ADDR_W-1:0]  csr_addr,
   input  wire logic [lsps_pkg::CSR_DATA_W-1:0]  csr_wdata
);
   import lsps_pkg::*;

   localparam int PHASE_WRAP = (PIXEL_COUNT < PHASE_MOD) ? PIXEL_COUNT : PHASE_MOD;

   localparam logic [1:0] ST_IDLE  = 2'd0;
   localparam logic [1:0] ST_DIV   = 2'd1;
   localparam logic [1:0] ST_SWEEP = 2'd2;

   // configuration
   pattern_type           pattern_ff;
   logic [MS_W-1:0]       step_ms_ff;
   logic [STEPS_W-1:0]    limit_ff;
   logic [COLOR_W-1:0]    lit_ff;

   // timing state
   logic [1:0]            state_ff, state_in;
   logic                  running_ff, run_in;
   logic                  init_ff, init_in;
   logic [PHASE_W-1:0]    phase_ff, phase_in;
   logic [PERIOD_W-1:0]   accum_ff, accum_in;
   logic [PERIOD_W-1:0]   period_ff, period_in;
   logic [STEPS_W-1:0]    steps_ff, steps_in;

   logic                  req_fire;
   logic                  clear_req;
   logic [PERIOD_W:0]     accum_sum;
   logic [PERIOD_W:0]     accum_diff;
   logic                  step_due;
   logic [PHASE_W:0]      phase_next;

   logic                  div_start;
   logic [DIVIDEND_W-1:0] div_dividend;
   logic                  div_busy;
   logic                  div_done;
   logic [DIVIDEND_W-1:0] div_quotient;

   logic                  sweep_start;
   sweep_cmd_type         sweep_cmd;
   logic                  sweep_busy;
   logic                  sweep_done;

   assign req_tready = (state_ff == ST_IDLE);
   assign req_fire   = req_tvalid && req_tready;
   assign clear_req  = req_tdata[0];

   // accumulate one tick and test against the step period
   assign accum_sum  = {1'b0, accum_ff} + (PERIOD_W + 1)'(TICK_FX);
   assign accum_diff = accum_sum - {1'b0, period_ff};
   assign step_due   = !accum_diff[PERIOD_W];
   assign phase_next = {1'b0, phase_ff} + (PHASE_W + 1)'(1);

   // period operand: scale by 256 unless no pattern is selected
   assign div_dividend = (pattern_ff == PAT_NONE) ? {8'h00, step_ms_ff} :
                                                    {step_ms_ff, 8'h00};

   // request decode and timing
   always_comb begin
      state_in    = state_ff;
      run_in      = running_ff;
      init_in     = init_ff;
      phase_in    = phase_ff;
      accum_in    = accum_ff;
      period_in   = period_ff;
      steps_in    = steps_ff;
      div_start   = 1'b0;
      sweep_start = 1'b0;
      sweep_cmd   = '{op: OP_COPY, color: '0, running: 1'b0};
      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               unique case (req_tuser)
                  REQ_START: begin
                     steps_in  = limit_ff;
                     init_in   = 1'b1;
                     accum_in  = '0;
                     run_in    = 1'b1;
                     div_start = 1'b1;
                     state_in  = ST_DIV;
                  end
                  REQ_STOP: begin
                     run_in = 1'b0;
                     if (clear_req) begin
                        sweep_start     = 1'b1;
                        sweep_cmd.op    = OP_FILL;
                        sweep_cmd.color = '0;
                        state_in        = ST_SWEEP;
                     end
                  end
                  REQ_TICK: begin
                     if (running_ff && init_ff) begin
                        // first tick: set up the strip
                        init_in     = 1'b0;
                        accum_in    = '0;
                        phase_in    = '0;
                        sweep_start = 1'b1;
                        state_in    = ST_SWEEP;
                        sweep_cmd.color = lit_ff;
                        unique case (pattern_ff)
                           PAT_STROBE: sweep_cmd.op = OP_FILL;
                           PAT_NONE:   sweep_cmd.op = OP_COPY;
                           default:    sweep_cmd.op = OP_ROTINIT;
                        endcase
                     end else if (running_ff && !step_due) begin
                        accum_in = accum_sum[PERIOD_W-1:0];
                     end else if (running_ff) begin
                        // step the pattern
                        accum_in    = accum_diff[PERIOD_W-1:0];
                        sweep_start = 1'b1;
                        state_in    = ST_SWEEP;
                        unique case (pattern_ff)
                           PAT_STROBE: begin
                              if (phase_next == (PHASE_W + 1)'(1)) begin
                                 sweep_cmd.op    = OP_FILL;
                                 sweep_cmd.color = '0;
                                 phase_in        = phase_next[PHASE_W-1:0];
                              end else if (phase_next >= (PHASE_W + 1)'(STROBE_STEPS)) begin
                                 sweep_cmd.op    = OP_FILL;
                                 sweep_cmd.color = lit_ff;
                                 phase_in        = '0;
                              end else begin
                                 phase_in = phase_next[PHASE_W-1:0];
                              end
                           end
                           PAT_RIGHT, PAT_LEFT: begin
                              sweep_cmd.op = (pattern_ff == PAT_RIGHT) ? OP_RIGHT : OP_LEFT;
                              if (phase_next >= (PHASE_W + 1)'(PHASE_WRAP)) begin
                                 phase_in = '0;
                              end else begin
                                 phase_in = phase_next[PHASE_W-1:0];
                              end
                           end
                           default: sweep_cmd.op = OP_COPY;
                        endcase
                        // count down the step limit
                        if (steps_ff != '0) begin
                           steps_in = steps_ff - STEPS_W'(1);
                           if (steps_ff == STEPS_W'(1)) begin
                              run_in = 1'b0;
                           end
                        end
                     end
                  end
                  default: ;
               endcase
            end
         end
         ST_DIV: begin
            // clamp the period from below
            if (div_done) begin
               period_in = (div_quotient > DIVIDEND_W'(PERIOD_MIN)) ?
                           PERIOD_W'(div_quotient) : PERIOD_W'(PERIOD_MIN);
               state_in  = ST_IDLE;
            end
         end
         ST_SWEEP: begin
            if (sweep_done) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
      sweep_cmd.running = run_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         running_ff <= 1'b0;
         init_ff    <= 1'b0;
         phase_ff   <= '0;
         accum_ff   <= '0;
         period_ff  <= PERIOD_W'(PERIOD_MIN);
         steps_ff   <= '0;
      end else begin
         state_ff   <= state_in;
         running_ff <= run_in;
         init_ff    <= init_in;
         phase_ff   <= phase_in;
         accum_ff   <= accum_in;
         period_ff  <= period_in;
         steps_ff   <= steps_in;
      end
   end

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         pattern_ff <= PAT_STROBE;
         step_ms_ff <= '0;
         limit_ff   <= '0;
         lit_ff     <= '0;
      end else if (csr_we) begin
         unique case (csr_addr)
            CSR_PATTERN: pattern_ff <= csr_wdata[PATTERN_W-1:0];
            CSR_STEP_MS: step_ms_ff <= csr_wdata[MS_W-1:0];
            CSR_LIMIT:   limit_ff   <= csr_wdata[STEPS_W-1:0];
            CSR_COLOR:   lit_ff     <= csr_wdata[COLOR_W-1:0];
         endcase
      end
   end

   lsps_div #(.PIXEL_COUNT(PIXEL_COUNT)) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .pattern  (pattern_ff),
      .busy     (div_busy),
      .done     (div_done),
      .quotient (div_quotient)
   );

   lsps_sweep #(.PIXEL_COUNT(PIXEL_COUNT)) u_sweep (
      .clock      (clock),
      .reset      (reset),
      .start      (sweep_start),
      .cmd        (sweep_cmd),
      .busy       (sweep_busy),
      .done       (sweep_done),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser)
   );

   `LSPS_ASSERT_NOW(a_period_floor, 1'b1, period_ff >= PERIOD_W'(PERIOD_MIN),
                    "step period below the minimum")
   `LSPS_ASSERT_NOW(a_ready_sweep_idle, req_tready, !sweep_busy,
                    "request taken while a sweep is running")
   `LSPS_ASSERT_NOW(a_div_state, state_ff == ST_DIV, div_busy || div_done,
                    "waiting on an idle divider")
   `LSPS_ASSERT_NOW(a_stopped_tick, req_fire && req_tuser == REQ_TICK && !running_ff,
                    !sweep_start, "tick while stopped started a sweep")

endmodule

`default_nettype wire
